FILE: rtl/ip6tl_pkg.sv
// Shared types, protocol numbers and helper functions for the IPv6
// transport header locator. Used by the walker, the top level and the testbench.
package ip6tl_pkg;

  localparam logic [2:0] MAX_HEADERS = 3'd4;

  localparam logic [7:0] PROTO_TCP      = 8'd6;
  localparam logic [7:0] PROTO_UDP      = 8'd17;
  localparam logic [7:0] PROTO_HOP      = 8'd0;
  localparam logic [7:0] PROTO_ROUTING  = 8'd43;
  localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
  localparam logic [7:0] PROTO_AH       = 8'd51;
  localparam logic [7:0] PROTO_FRAGMENT = 8'd44;

  localparam int unsigned LEN_W = 12;
  localparam logic [LEN_W-1:0] BASE_HEADER_BYTES = 12'd40;
  localparam logic [LEN_W-1:0] FRAG_HEADER_BYTES = 12'd8;
  localparam logic [15:0]      BASE_NEXT_INDEX   = 16'd6;
  localparam logic [15:0]      FRAG_OFFSET_HI    = 16'd2;
  localparam logic [15:0]      FRAG_OFFSET_LO    = 16'd3;
  localparam logic [7:0]       FRAG_BITS_MASK    = 8'hF9;

  typedef enum logic [3:0] {
    KIND_BASE = 4'b0001,
    KIND_EXT  = 4'b0010,
    KIND_AH   = 4'b0100,
    KIND_FRAG = 4'b1000
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_FOUND  = 2'd0,
    VERDICT_BYPASS = 2'd1,
    VERDICT_DROP   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] base_offset;
  } item_t;

  typedef struct packed {
    logic        hit;
    verdict_t    verdict;
    logic [7:0]  protocol;
    logic [15:0] offset;
  } res_t;

  function automatic logic is_transport(input logic [7:0] p);
    return (p == PROTO_TCP) || (p == PROTO_UDP);
  endfunction

  function automatic logic is_chain_header(input logic [7:0] p);
    return (p == PROTO_HOP) || (p == PROTO_ROUTING) || (p == PROTO_DSTOPTS) ||
           (p == PROTO_AH) || (p == PROTO_FRAGMENT);
  endfunction

endpackage

FILE: rtl/ip6tl_if.sv
// Valid/ready channel interfaces for the packet byte input and the verdict
// output of the locator. Depends on nothing.
interface ip6tl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] base_offset;

  modport source (output valid, output data_byte, output last_byte,
                  output base_offset, input ready);
  modport sink   (input valid, input data_byte, input last_byte,
                  input base_offset, output ready);
endinterface

interface ip6tl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [7:0]  transport_protocol;
  logic [15:0] transport_offset;

  modport source (output valid, output verdict, output transport_protocol,
                  output transport_offset, input ready);
  modport sink   (input valid, input verdict, input transport_protocol,
                  input transport_offset, output ready);
endinterface

FILE: rtl/ip6tl_walk.sv
// Next-header chain walker: per-packet state registers and the one-byte
// update logic that decides the verdict. Depends on ip6tl_pkg.
module ip6tl_walk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  ip6tl_pkg::item_t item,
  output ip6tl_pkg::res_t  res
);

  logic [15:0]         pos_r, pos_nxt;
  logic [15:0]         start_r, start_nxt;
  logic [7:0]          pend_r, pend_nxt;
  logic [2:0]          seen_r, seen_nxt;
  ip6tl_pkg::kind_t    kind_r, kind_nxt;
  logic [7:0]          saved_r, saved_nxt;
  logic [7:0]          base_r, base_nxt;
  logic                given_r, given_nxt;

  always_comb begin
    logic [15:0]                 rel;
    logic [ip6tl_pkg::LEN_W-1:0] len;
    logic [15:0]                 len16;
    logic [15:0]                 next_start;
    logic [7:0]                  b;
    logic                        done;

    b          = item.data_byte;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    pend_nxt   = pend_r;
    seen_nxt   = seen_r;
    kind_nxt   = kind_r;
    saved_nxt  = saved_r;
    base_nxt   = (pos_r == 16'd0) ? item.base_offset : base_r;
    given_nxt  = given_r;
    res        = '{hit: 1'b0, verdict: ip6tl_pkg::VERDICT_BYPASS,
                   protocol: 8'd0, offset: 16'd0};
    rel        = pos_r - start_r;
    len        = '0;
    len16      = 16'd0;
    next_start = start_r;
    done       = 1'b0;

    if (!given_r) begin
      case (kind_r)
        ip6tl_pkg::KIND_BASE: begin
          if (rel == ip6tl_pkg::BASE_NEXT_INDEX) pend_nxt = b;
          len = ip6tl_pkg::BASE_HEADER_BYTES;
        end
        ip6tl_pkg::KIND_FRAG: begin
          if (rel == 16'd0) pend_nxt = b;
          else if (rel == ip6tl_pkg::FRAG_OFFSET_HI) saved_nxt = b;
          else if (rel == ip6tl_pkg::FRAG_OFFSET_LO)
            saved_nxt = saved_r | (b & ip6tl_pkg::FRAG_BITS_MASK);
          len = ip6tl_pkg::FRAG_HEADER_BYTES;
        end
        ip6tl_pkg::KIND_EXT, ip6tl_pkg::KIND_AH: begin
          if (rel == 16'd0) pend_nxt = b;
          else if (rel == 16'd1) saved_nxt = b;
          // AH counts 4-byte units minus two, the others 8-byte units minus one.
          if (rel != 16'd0) begin
            if (kind_r == ip6tl_pkg::KIND_AH)
              len = ip6tl_pkg::LEN_W'({saved_nxt, 2'b00}) + 12'd8;
            else
              len = ip6tl_pkg::LEN_W'({saved_nxt, 3'b000}) + 12'd8;
          end
        end
        default: len = '0;
      endcase

      len16      = 16'(len);
      next_start = start_r + len16;
      done       = (len != '0) && (rel == len16 - 16'd1);

      if (done) begin
        if (kind_r == ip6tl_pkg::KIND_FRAG) begin
          res.hit = 1'b1;
          if (saved_nxt != 8'd0) begin
            res.verdict = ip6tl_pkg::VERDICT_BYPASS;
          end else if (ip6tl_pkg::is_transport(pend_nxt)) begin
            res.verdict  = ip6tl_pkg::VERDICT_FOUND;
            res.protocol = pend_nxt;
            res.offset   = 16'(base_nxt) + next_start;
          end else if (ip6tl_pkg::is_chain_header(pend_nxt)) begin
            res.verdict = ip6tl_pkg::VERDICT_DROP;
          end else begin
            res.verdict = ip6tl_pkg::VERDICT_BYPASS;
          end
        end else begin
          if (kind_r != ip6tl_pkg::KIND_BASE) seen_nxt = seen_r + 3'd1;
          if (seen_nxt >= ip6tl_pkg::MAX_HEADERS) begin
            res.hit     = 1'b1;
            res.verdict = ip6tl_pkg::VERDICT_DROP;
          end else if (ip6tl_pkg::is_transport(pend_nxt)) begin
            res.hit      = 1'b1;
            res.verdict  = ip6tl_pkg::VERDICT_FOUND;
            res.protocol = pend_nxt;
            res.offset   = 16'(base_nxt) + next_start;
          end else if (ip6tl_pkg::is_chain_header(pend_nxt)) begin
            // Continue the walk into the next extension header.
            if (pend_nxt == ip6tl_pkg::PROTO_FRAGMENT) kind_nxt = ip6tl_pkg::KIND_FRAG;
            else if (pend_nxt == ip6tl_pkg::PROTO_AH) kind_nxt = ip6tl_pkg::KIND_AH;
            else kind_nxt = ip6tl_pkg::KIND_EXT;
            start_nxt = next_start;
            pend_nxt  = 8'd0;
            saved_nxt = 8'd0;
          end else begin
            res.hit     = 1'b1;
            res.verdict = ip6tl_pkg::VERDICT_BYPASS;
          end
        end
      end

      if (!res.hit && item.last_byte) begin
        res.hit     = 1'b1;
        res.verdict = ip6tl_pkg::VERDICT_DROP;
      end
      given_nxt = res.hit;
    end

    if (item.last_byte) begin
      pos_nxt   = 16'd0;
      start_nxt = 16'd0;
      pend_nxt  = 8'd0;
      seen_nxt  = 3'd0;
      kind_nxt  = ip6tl_pkg::KIND_BASE;
      saved_nxt = 8'd0;
      given_nxt = 1'b0;
    end else if (pos_r != 16'hFFFF) begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 16'd0;
      start_r <= 16'd0;
      pend_r  <= 8'd0;
      seen_r  <= 3'd0;
      kind_r  <= ip6tl_pkg::KIND_BASE;
      saved_r <= 8'd0;
      base_r  <= 8'd0;
      given_r <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
      seen_r  <= seen_nxt;
      kind_r  <= kind_nxt;
      saved_r <= saved_nxt;
      base_r  <= base_nxt;
      given_r <= given_nxt;
    end
  end

endmodule

FILE: rtl/ipv6_transport_header_locator.sv
// Top level of the IPv6 transport header locator: input register, chain
// walker and result register. Depends on ip6tl_pkg, ip6tl_if and ip6tl_walk.
//
// Usage: feed the packet one byte per item on in_chan, starting with the
// first byte of the IPv6 header, with last_byte set on the final byte and
// base_offset valid on the first byte. For each packet exactly one result
// item appears on out_chan: verdict found (with TCP/UDP protocol and the
// absolute transport header offset), bypass, or drop.
// Timing: an accepted byte is walked out of the input register once the
// result register is free; a result it decides is registered in the result
// register. Throughput is one byte per cycle while the receiver does not stall,
// set by the single registered pass of the walker; most bytes cause no result.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// walker to the start of a packet.
// When the receiver stalls, the held result blocks the walker; the input
// register still takes one more byte if it is empty, then in_chan.ready goes
// low until the result is taken.
module ipv6_transport_header_locator (
  input logic         clk,
  input logic         rst_n,
  ip6tl_in_if.sink    in_chan,
  ip6tl_out_if.source out_chan
);

  logic              s1_valid_r, s1_valid_nxt;
  ip6tl_pkg::item_t  s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  ip6tl_pkg::res_t   out_res_r;
  ip6tl_pkg::res_t   walk_res;
  logic              out_free;
  logic              step;
  logic              in_accept;

  assign out_free     = !out_valid_r || out_chan.ready;
  assign step         = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_accept    = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? (step && walk_res.hit) : out_valid_r;

  ip6tl_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .res   (walk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{data_byte: in_chan.data_byte, last_byte: in_chan.last_byte,
                     base_offset: in_chan.base_offset};
    end
    if (step && walk_res.hit) begin
      out_res_r <= walk_res;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.verdict            = out_res_r.verdict;
  assign out_chan.transport_protocol = out_res_r.protocol;
  assign out_chan.transport_offset   = out_res_r.offset;

  // A found verdict always names TCP or UDP.
  a_found_proto: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.verdict == ip6tl_pkg::VERDICT_FOUND) |->
      (out_res_r.protocol == ip6tl_pkg::PROTO_TCP ||
       out_res_r.protocol == ip6tl_pkg::PROTO_UDP))
    else $error("found verdict without transport protocol");

  // Bypass and drop carry zero protocol and offset.
  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.verdict != ip6tl_pkg::VERDICT_FOUND) |->
      (out_res_r.protocol == 8'd0 && out_res_r.offset == 16'd0))
    else $error("non-found verdict with payload");

  // A byte held behind a stalled result is not lost.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("input byte dropped during stall");

endmodule

FILE: verif/tb_ipv6_transport_header_locator.sv
// Self-checking testbench for ipv6_transport_header_locator: walks each accepted packet
// byte through a local chain-walk predictor and checks every verdict against it.
// Depends on rtl/ip6tl_pkg.sv, rtl/ip6tl_if.sv and the block's RTL.
module tb_ipv6_transport_header_locator;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [7:0] base;
    bit         eager;
  } byte_slot_t;

  typedef struct {
    ip6tl_pkg::verdict_t verdict;
    logic [7:0]          protocol;
    logic [15:0]         offset;
  } verdict_rec_t;

  logic clk;
  logic rst_n;

  ip6tl_in_if  in_chan ();
  ip6tl_out_if out_chan ();

  ipv6_transport_header_locator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Bytes waiting to be offered, and verdicts waiting to come out.
  byte_slot_t   byte_feed[$];
  verdict_rec_t verdict_q[$];
  logic [7:0]   pkt_bytes[$];

  int bytes_queued  = 0;
  int bytes_in      = 0;
  int open_verdicts = 0;
  int faults        = 0;
  int hold_at       = 32'h7fffffff;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit calm          = 1'b0;

  // Chain-walk state of the predictor, as it stands after reset.
  logic [15:0]      pos_r    = '0;
  logic [15:0]      hstart_r = '0;
  logic [7:0]       nh_r     = '0;
  logic [7:0]       field_r  = '0;
  logic [7:0]       base_r   = '0;
  logic [2:0]       seen_r   = '0;
  ip6tl_pkg::kind_t kind_r   = ip6tl_pkg::KIND_BASE;
  bit               decided_r = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic push_verdict(input ip6tl_pkg::verdict_t v, input logic [7:0] p,
                              input logic [15:0] off);
    verdict_rec_t rec;
    rec.verdict  = v;
    rec.protocol = p;
    rec.offset   = off;
    verdict_q.push_back(rec);
    open_verdicts++;
  endtask

  function automatic bit is_chain(input logic [7:0] p);
    return p == ip6tl_pkg::PROTO_HOP || p == ip6tl_pkg::PROTO_ROUTING ||
           p == ip6tl_pkg::PROTO_DSTOPTS || p == ip6tl_pkg::PROTO_AH ||
           p == ip6tl_pkg::PROTO_FRAGMENT;
  endfunction

  task automatic walk_byte(input logic [7:0] b, input logic last, input logic [7:0] base);
    logic [15:0] rel;
    int unsigned hlen;
    int unsigned nxt;
    bit          got;
    got = 1'b0;
    if (pos_r == 16'd0) base_r = base;
    if (!decided_r) begin
      rel  = pos_r - hstart_r;
      hlen = 0;
      case (kind_r)
        ip6tl_pkg::KIND_BASE: begin
          if (rel == ip6tl_pkg::BASE_NEXT_INDEX) nh_r = b;
          hlen = 40;
        end
        ip6tl_pkg::KIND_FRAG: begin
          if (rel == 16'd0) nh_r = b;
          else if (rel == 16'd2) field_r = b;
          else if (rel == 16'd3) field_r = field_r | (b & ip6tl_pkg::FRAG_BITS_MASK);
          hlen = 8;
        end
        default: begin
          if (rel == 16'd0) nh_r = b;
          else if (rel == 16'd1) field_r = b;
          if (rel >= 16'd1) begin
            hlen = (kind_r == ip6tl_pkg::KIND_AH) ? (int'(field_r) + 2) * 4 :
                                                    (int'(field_r) + 1) * 8;
          end
        end
      endcase
      if (hlen != 0 && rel == hlen - 1) begin
        got = 1'b1;
        if (kind_r == ip6tl_pkg::KIND_FRAG) begin
          // A fragment header decides on its own: no further walking.
          if (field_r != 8'd0) begin
            push_verdict(ip6tl_pkg::VERDICT_BYPASS, 8'd0, 16'd0);
          end else if (nh_r == ip6tl_pkg::PROTO_TCP || nh_r == ip6tl_pkg::PROTO_UDP) begin
            push_verdict(ip6tl_pkg::VERDICT_FOUND, nh_r, 16'(base_r + hstart_r + 16'd8));
          end else if (is_chain(nh_r)) begin
            push_verdict(ip6tl_pkg::VERDICT_DROP, 8'd0, 16'd0);
          end else begin
            push_verdict(ip6tl_pkg::VERDICT_BYPASS, 8'd0, 16'd0);
          end
        end else begin
          if (kind_r != ip6tl_pkg::KIND_BASE) seen_r = seen_r + 3'd1;
          nxt = int'(hstart_r) + hlen;
          if (seen_r >= ip6tl_pkg::MAX_HEADERS) begin
            push_verdict(ip6tl_pkg::VERDICT_DROP, 8'd0, 16'd0);
          end else if (nh_r == ip6tl_pkg::PROTO_TCP || nh_r == ip6tl_pkg::PROTO_UDP) begin
            push_verdict(ip6tl_pkg::VERDICT_FOUND, nh_r, 16'(int'(base_r) + nxt));
          end else if (is_chain(nh_r)) begin
            kind_r   = (nh_r == ip6tl_pkg::PROTO_FRAGMENT) ? ip6tl_pkg::KIND_FRAG :
                       (nh_r == ip6tl_pkg::PROTO_AH) ? ip6tl_pkg::KIND_AH :
                                                       ip6tl_pkg::KIND_EXT;
            hstart_r = 16'(nxt);
            nh_r     = 8'd0;
            field_r  = 8'd0;
            got      = 1'b0;
          end else begin
            push_verdict(ip6tl_pkg::VERDICT_BYPASS, 8'd0, 16'd0);
          end
        end
      end
      if (!got && last) begin
        push_verdict(ip6tl_pkg::VERDICT_DROP, 8'd0, 16'd0);
        got = 1'b1;
      end
      if (got) decided_r = 1'b1;
    end
    if (last) begin
      pos_r     = '0;
      hstart_r  = '0;
      nh_r      = '0;
      seen_r    = '0;
      kind_r    = ip6tl_pkg::KIND_BASE;
      field_r   = '0;
      decided_r = 1'b0;
    end else if (pos_r != 16'hFFFF) begin
      pos_r = pos_r + 16'd1;
    end
  endtask

  task automatic note_fault(input string what);
    faults++;
    if (faults <= 10) $display("%s", what);
  endtask

  // Packet assembly helpers: each appends one header, or noise bytes, to pkt_bytes.
  task automatic put_noise(input int n);
    repeat (n) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_base(input logic [7:0] nh);
    for (int i = 0; i < 40; i++) begin
      pkt_bytes.push_back(i == 6 ? nh : 8'($urandom_range(255)));
    end
  endtask

  task automatic put_ext(input logic [7:0] nh, input logic [7:0] len);
    pkt_bytes.push_back(nh);
    pkt_bytes.push_back(len);
    put_noise((int'(len) + 1) * 8 - 2);
  endtask

  task automatic put_ah(input logic [7:0] nh, input logic [7:0] len);
    pkt_bytes.push_back(nh);
    pkt_bytes.push_back(len);
    put_noise((int'(len) + 2) * 4 - 2);
  endtask

  task automatic put_frag(input logic [7:0] nh, input logic [7:0] hi, input logic [7:0] lo);
    pkt_bytes.push_back(nh);
    pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(hi);
    pkt_bytes.push_back(lo);
    put_noise(4);
  endtask

  function automatic logic [7:0] chain_len();
    return ($urandom_range(63) == 0) ? 8'($urandom_range(31, 4)) : 8'($urandom_range(3));
  endfunction

  function automatic logic [7:0] chain_proto();
    case ($urandom_range(4))
      0:       return ip6tl_pkg::PROTO_HOP;
      1:       return ip6tl_pkg::PROTO_ROUTING;
      2:       return ip6tl_pkg::PROTO_DSTOPTS;
      3:       return ip6tl_pkg::PROTO_AH;
      default: return ip6tl_pkg::PROTO_FRAGMENT;
    endcase
  endfunction

  task automatic ship(input logic [7:0] base, input bit eager);
    byte_slot_t s;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      s.data  = pkt_bytes[i];
      s.last  = (i == pkt_bytes.size() - 1);
      // Only the first byte's base offset matters; the rest carry noise.
      s.base  = (i == 0) ? base : 8'($urandom_range(255));
      s.eager = eager;
      byte_feed.push_back(s);
      bytes_queued++;
    end
    pkt_bytes.delete();
  endtask

  task automatic random_packet(input bit eager);
    logic [7:0] chain[$];
    logic [7:0] tail;
    logic [7:0] nh;
    logic [7:0] base;
    int         style;
    int         depth;
    int         cut;
    style = $urandom_range(99);
    case ($urandom_range(3))
      0:       base = 8'd0;
      1:       base = 8'd255;
      default: base = 8'($urandom_range(255));
    endcase
    if (style >= 88) begin
      put_noise($urandom_range(1, 80));
    end else begin
      depth = $urandom_range(5);
      repeat (depth) chain.push_back(chain_proto());
      case ($urandom_range(5))
        0, 1:    tail = ip6tl_pkg::PROTO_TCP;
        2, 5:    tail = ip6tl_pkg::PROTO_UDP;
        3:       tail = 8'($urandom_range(255));
        default: tail = chain_proto();
      endcase
      put_base(depth != 0 ? chain[0] : tail);
      for (int i = 0; i < depth; i++) begin
        nh = (i + 1 < depth) ? chain[i + 1] : tail;
        if (chain[i] == ip6tl_pkg::PROTO_FRAGMENT) begin
          put_frag(nh, ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'd0,
                   ($urandom_range(2) == 0) ? 8'($urandom_range(255)) :
                                              8'($urandom_range(255)) &
                                              ~ip6tl_pkg::FRAG_BITS_MASK);
        end else if (chain[i] == ip6tl_pkg::PROTO_AH) begin
          put_ah(nh, chain_len());
        end else begin
          put_ext(nh, chain_len());
        end
      end
      put_noise($urandom_range(12));
      if (style >= 72) begin
        // Truncated packet: cut it short anywhere.
        cut = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end
    ship(base, eager);
  endtask

  // Sender: when the channel is free, offers the next byte, always for eager packets and at random otherwise.
  always @(posedge clk) begin : feed_bytes
    byte_slot_t s;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        walk_byte(in_chan.data_byte, in_chan.last_byte, in_chan.base_offset);
        bytes_in++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (byte_feed.size() != 0 && (byte_feed[0].eager || $urandom_range(99) >= 36)) begin
          s = byte_feed.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.data_byte   <= s.data;
          in_chan.last_byte   <= s.last;
          in_chan.base_offset <= s.base;
          calm = s.eager;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_in >= hold_at) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks each accepted verdict against the oldest prediction.
  always @(posedge clk) begin : take_verdicts
    verdict_rec_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (open_verdicts == 0) begin
          note_fault($sformatf("unexpected verdict %0d proto %0d offset %0d",
                               out_chan.verdict, out_chan.transport_protocol,
                               out_chan.transport_offset));
        end else begin
          want = verdict_q.pop_front();
          open_verdicts--;
          if (out_chan.verdict !== want.verdict ||
              out_chan.transport_protocol !== want.protocol ||
              out_chan.transport_offset !== want.offset) begin
            note_fault($sformatf("verdict mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.verdict, want.protocol, want.offset, out_chan.verdict,
                                 out_chan.transport_protocol, out_chan.transport_offset));
          end
        end
      end
      out_chan.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 36);
    end
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.data_byte   = 8'd0;
    in_chan.last_byte   = 1'b0;
    in_chan.base_offset = 8'd0;
    out_chan.ready      = 1'b0;
    rst_n               = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets: each kind of header and each way a walk can end.
    put_base(ip6tl_pkg::PROTO_TCP);
    put_noise(4);
    ship(8'd0, 1'b0);
    put_base(ip6tl_pkg::PROTO_UDP);
    ship(8'd255, 1'b0);
    put_base(8'd59);
    put_noise(3);
    ship(8'($urandom_range(255)), 1'b0);
    put_base(ip6tl_pkg::PROTO_HOP);
    put_ext(ip6tl_pkg::PROTO_TCP, 8'd0);
    ship(8'd17, 1'b0);
    put_base(ip6tl_pkg::PROTO_ROUTING);
    put_ext(ip6tl_pkg::PROTO_DSTOPTS, 8'd1);
    put_ext(ip6tl_pkg::PROTO_UDP, 8'd0);
    put_noise(2);
    ship(8'd200, 1'b0);
    put_base(ip6tl_pkg::PROTO_AH);
    put_ah(ip6tl_pkg::PROTO_AH, 8'd0);
    put_ah(ip6tl_pkg::PROTO_TCP, 8'd1);
    ship(8'd3, 1'b0);
    // Atomic fragment; the reserved bits of the offset field are ignored.
    put_base(ip6tl_pkg::PROTO_FRAGMENT);
    put_frag(ip6tl_pkg::PROTO_TCP, 8'd0, 8'h06);
    ship(8'd255, 1'b0);
    put_base(ip6tl_pkg::PROTO_FRAGMENT);
    put_frag(ip6tl_pkg::PROTO_UDP, 8'h01, 8'd0);
    ship(8'd0, 1'b0);
    put_base(ip6tl_pkg::PROTO_FRAGMENT);
    put_frag(ip6tl_pkg::PROTO_TCP, 8'd0, 8'h01);
    ship(8'd9, 1'b0);
    put_base(ip6tl_pkg::PROTO_FRAGMENT);
    put_frag(ip6tl_pkg::PROTO_HOP, 8'd0, 8'd0);
    ship(8'd9, 1'b0);
    put_base(ip6tl_pkg::PROTO_FRAGMENT);
    put_frag(8'd58, 8'd0, 8'd0);
    ship(8'd9, 1'b0);
    // Four length-counted headers exhaust the walk; three do not.
    put_base(ip6tl_pkg::PROTO_HOP);
    put_ext(ip6tl_pkg::PROTO_ROUTING, 8'd0);
    put_ext(ip6tl_pkg::PROTO_DSTOPTS, 8'd0);
    put_ext(ip6tl_pkg::PROTO_AH, 8'd0);
    put_ah(ip6tl_pkg::PROTO_TCP, 8'd0);
    ship(8'd1, 1'b0);
    put_base(ip6tl_pkg::PROTO_HOP);
    put_ext(ip6tl_pkg::PROTO_ROUTING, 8'd0);
    put_ext(ip6tl_pkg::PROTO_DSTOPTS, 8'd0);
    put_ext(ip6tl_pkg::PROTO_TCP, 8'd0);
    ship(8'd1, 1'b0);
    // A maximum-length options header, cut off well before its end.
    put_base(ip6tl_pkg::PROTO_DSTOPTS);
    put_ext(ip6tl_pkg::PROTO_UDP, 8'd255);
    while (pkt_bytes.size() > 64) void'(pkt_bytes.pop_back());
    ship(8'd128, 1'b0);
    put_noise(1);
    ship(8'd77, 1'b0);
    put_base(ip6tl_pkg::PROTO_ROUTING);
    put_ext(ip6tl_pkg::PROTO_TCP, 8'd2);
    void'(pkt_bytes.pop_back());
    ship(8'd5, 1'b0);

    // Let everything drain before the random traffic starts.
    wait (bytes_in == bytes_queued && open_verdicts == 0);
    repeat (8) @(posedge clk);

    hold_at = bytes_queued + 300;
    for (int n = 0; bytes_queued - hold_at < 600; n++) begin
      random_packet(n >= 4 && n < 9);
    end

    wait (bytes_in == bytes_queued && open_verdicts == 0);
    repeat (8) @(posedge clk);
    if (faults == 0 && open_verdicts == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
